// ----- src/ttt_pkg.sv -----
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types, constants and result codes of the timed task table.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int MAX_FIRE    = 32;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SCAN_W      = $clog2(TABLE_DEPTH + 1);
    localparam int FIRE_CNT_W  = $clog2(MAX_FIRE + 1);

    localparam int TAG_W       = 16;
    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 16;
    localparam int KIND_W      = 2;
    localparam int SLOT_IDX_W  = 5;

    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 24;

    localparam logic [KIND_W-1:0] KIND_ADDED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic [TIME_W-1:0]     due;
        logic [TAG_W-1:0]      tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- src/ttt_ram.sv -----
// ----------------------------------------------------------------------------
// ttt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/timed_task_table_core.sv -----
// ----------------------------------------------------------------------------
// timed_task_table_core
// Table of timed tasks: add stores a task in the lowest free slot, a tick
// scans the table from slot 0 and fires, re-arms or frees every due entry.
//
//   channel  dir  tdata                                   tuser        tlast
//   s_       in   tag, due_time, repeat_interval, now     mode         -
//   m_       out  slot_index, fired_tag                   result_kind  last_result
//
// A tick reads the slots in turn through the single read port of the entry
// RAM, one slot read per cycle while no stalled m_ side holds the scan.
// A disabled tick skips the scan and reports only the final result.
// Reset clears the valid bits and the state; RAM contents need no clearing.
// A stalled m_ side holds the scan at a fire that must emit a result; the s_ side takes no transfer mid-tick.
// ----------------------------------------------------------------------------
module timed_task_table_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // task_tag[15:0], due_time[47:16], repeat_interval[63:48], current_time[95:64]
    input  logic [ttt_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot_index[4:0], fired_tag[20:5], zero[23:21]
    output logic [ttt_pkg::M_TDATA_W-1:0]   m_tdata,
    // result_kind
    output logic [ttt_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic                              enable_reg;
    logic [ttt_pkg::TABLE_DEPTH-1:0]   valid_reg, valid_next;
    logic [ttt_pkg::SCAN_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                              eval_valid_reg, eval_valid_next;
    logic [ttt_pkg::SLOT_W-1:0]        eval_slot_reg, eval_slot_next;
    logic [ttt_pkg::TIME_W-1:0]        now_reg, now_next;
    logic [ttt_pkg::FIRE_CNT_W-1:0]    fire_cnt_reg, fire_cnt_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [ttt_pkg::SLOT_IDX_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [ttt_pkg::TAG_W-1:0]         pend_tag_reg, pend_tag_next;

    logic                              out_valid_reg, out_valid_next;
    logic [ttt_pkg::KIND_W-1:0]        out_kind_reg, out_kind_next;
    logic [ttt_pkg::SLOT_IDX_W-1:0]    out_slot_reg, out_slot_next;
    logic [ttt_pkg::TAG_W-1:0]         out_tag_reg, out_tag_next;
    logic                              out_last_reg, out_last_next;

    logic                              ram_wr_en;
    logic [ttt_pkg::SLOT_W-1:0]        ram_wr_addr;
    ttt_pkg::entry_t                   ram_wr_data;
    logic                              ram_rd_en;
    logic [ttt_pkg::SLOT_W-1:0]        ram_rd_addr;
    logic [ttt_pkg::ENTRY_W-1:0]       ram_rd_raw;
    ttt_pkg::entry_t                   rd_entry;

    logic                              out_free;
    logic                              in_xfer;
    logic                              table_full;
    logic [ttt_pkg::SLOT_W-1:0]        free_slot;
    logic                              fire;
    logic                              advance;

    logic [ttt_pkg::TAG_W-1:0]         in_tag;
    logic [ttt_pkg::TIME_W-1:0]        in_due;
    logic [ttt_pkg::INTERVAL_W-1:0]    in_interval;
    logic [ttt_pkg::TIME_W-1:0]        in_now;

    assign in_tag      = s_tdata[15:0];
    assign in_due      = s_tdata[47:16];
    assign in_interval = s_tdata[63:48];
    assign in_now      = s_tdata[95:64];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer  = s_tvalid && s_tready;

    assign rd_entry = ttt_pkg::entry_t'(ram_rd_raw);

    always_comb begin
        table_full = 1'b1;
        free_slot  = '0;
        for (int i = ttt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                table_full = 1'b0;
                free_slot  = ttt_pkg::SLOT_W'(i);
            end
        end
    end

    assign fire = eval_valid_reg && valid_reg[eval_slot_reg]
                  && (rd_entry.due <= now_reg)
                  && (fire_cnt_reg < ttt_pkg::FIRE_CNT_W'(ttt_pkg::MAX_FIRE));
    assign advance = !(fire && pend_valid_reg && !out_free);

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_slot_next  = eval_slot_reg;
        now_next        = now_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;

        ram_wr_en       = 1'b0;
        ram_wr_addr     = free_slot;
        ram_wr_data     = '{interval: in_interval, due: in_due, tag: in_tag};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = scan_idx_reg[ttt_pkg::SLOT_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == ttt_pkg::MODE_ADD) begin
                        out_valid_next = 1'b1;
                        out_tag_next   = '0;
                        out_last_next  = 1'b1;
                        if (table_full) begin
                            out_kind_next = ttt_pkg::KIND_FULL;
                            out_slot_next = '0;
                        end else begin
                            out_kind_next         = ttt_pkg::KIND_ADDED;
                            out_slot_next         = ttt_pkg::SLOT_IDX_W'(free_slot);
                            ram_wr_en             = 1'b1;
                            valid_next[free_slot] = 1'b1;
                        end
                    end else begin
                        now_next        = in_now;
                        scan_idx_next   = '0;
                        eval_valid_next = 1'b0;
                        fire_cnt_next   = '0;
                        pend_valid_next = 1'b0;
                        state_next      = enable_reg ? ST_SCAN : ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    if (fire) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = ttt_pkg::KIND_FIRED;
                            out_slot_next  = pend_slot_reg;
                            out_tag_next   = pend_tag_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = ttt_pkg::SLOT_IDX_W'(eval_slot_reg);
                        pend_tag_next   = rd_entry.tag;
                        fire_cnt_next   = fire_cnt_reg + 1'b1;
                        if (rd_entry.interval != '0) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = eval_slot_reg;
                            ram_wr_data = '{interval: rd_entry.interval,
                                            due: now_reg
                                                 + ttt_pkg::TIME_W'(rd_entry.interval),
                                            tag: rd_entry.tag};
                        end else begin
                            valid_next[eval_slot_reg] = 1'b0;
                        end
                    end
                    if (scan_idx_reg < ttt_pkg::SCAN_W'(ttt_pkg::TABLE_DEPTH)) begin
                        ram_rd_en       = 1'b1;
                        eval_valid_next = 1'b1;
                        eval_slot_next  = scan_idx_reg[ttt_pkg::SLOT_W-1:0];
                        scan_idx_next   = scan_idx_reg + 1'b1;
                    end else begin
                        eval_valid_next = 1'b0;
                        if (!eval_valid_reg) begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        out_kind_next = ttt_pkg::KIND_FIRED;
                        out_slot_next = pend_slot_reg;
                        out_tag_next  = pend_tag_reg;
                    end else begin
                        out_kind_next = ttt_pkg::KIND_NONE;
                        out_slot_next = '0;
                        out_tag_next  = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            enable_reg     <= 1'b1;
            valid_reg      <= '0;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            fire_cnt_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            valid_reg      <= valid_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            scan_idx_reg   <= scan_idx_next;
            fire_cnt_reg   <= fire_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        eval_slot_reg <= eval_slot_next;
        now_reg       <= now_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_tag_reg   <= out_tag_next;
        out_last_reg  <= out_last_next;
    end

    ttt_ram #(
        .WIDTH (ttt_pkg::ENTRY_W),
        .DEPTH (ttt_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_tag_reg, out_slot_reg};

    a_fire_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= ttt_pkg::FIRE_CNT_W'(ttt_pkg::MAX_FIRE))
        else $error("fire count beyond limit");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!eval_valid_reg && !pend_valid_reg))
        else $error("scan pipeline not drained in idle");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("RAM write and read hit the same slot");

    a_add_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_tuser == ttt_pkg::MODE_ADD) && !table_full)
        |=> valid_reg[$past(free_slot)])
        else $error("added slot not marked valid");

    a_fire_needs_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> (state_reg == ST_SCAN))
        else $error("fire outside scan");

endmodule
